>>> src/aipt_pkg.sv
// aipt_pkg: shared constants and types of the inverse affine point transform
// used by every module under src, depends on nothing

package aipt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int QW        = 31;
    localparam int NW        = 32 + FRAC_BITS;
    localparam int DW        = 65 - FRAC_BITS;
    localparam int CW        = (NW > DW) ? NW : DW;
    localparam int PIPE_LAT  = 4 + QW + 1;
    localparam int CNT_W     = $clog2(PIPE_LAT + 1);

    localparam logic signed [31:0] ONE_FIX  = 32'sd1 <<< FRAC_BITS;
    localparam logic [QW-1:0]      TERM_MAX = {QW{1'b1}};

    localparam logic [2:0] REG_LIN_A   = 3'd0;
    localparam logic [2:0] REG_LIN_B   = 3'd1;
    localparam logic [2:0] REG_LIN_C   = 3'd2;
    localparam logic [2:0] REG_LIN_D   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;

    typedef struct packed {
        logic [LANES-1:0][NW-1:0] rem;
        logic [LANES-1:0][QW-1:0] quo;
        logic [LANES-1:0]         neg;
        logic [LANES-1:0]         ovf;
        logic [DW-1:0]            dabs;
        logic                     sing;
    } cell_t;

    // lane order: ia, ib, ic, id
    typedef struct packed {
        logic [LANES-1:0][31:0] term;
        logic                   sat;
        logic                   sing;
    } terms_t;

endpackage

>>> src/affine_inverse_point_transform_unit.sv
// affine_inverse_point_transform_unit: top level, configuration registers
// depends on aipt_pkg, aipt_inv_terms and aipt_map
//
// channel   direction  handshake                  payload
// request   in         start && !busy             point_x, point_y
// result    out        done strobe, one cycle     x_out, y_out, singular, saturated
// config    in         cfg_valid && cfg_ready     cfg_index, cfg_data
//
// one request per cycle once busy is low; each result passes the difference, product
// and saturated output registers; inverse terms come from a free-running chain of 31
// division cells fed by the config registers; after reset and after every config write
// busy stays high while the determinant and the cell chain settle
// the receiver cannot stall: results go out on done for one cycle
// cfg_ready is always high

module affine_inverse_point_transform_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   point_x,
    input  logic signed [31:0]   point_y,
    output logic                 done,
    output logic signed [47:0]   x_out,
    output logic signed [47:0]   y_out,
    output logic                 singular,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic signed [31:0]          lin_a_reg;
    logic signed [31:0]          lin_b_reg;
    logic signed [31:0]          lin_c_reg;
    logic signed [31:0]          lin_d_reg;
    logic signed [31:0]          shift_x_reg;
    logic signed [31:0]          shift_y_reg;
    logic [aipt_pkg::CNT_W-1:0]  cnt_reg;
    logic [aipt_pkg::CNT_W-1:0]  cnt_next;
    logic                        cfg_wr;
    logic                        accept;
    aipt_pkg::terms_t            terms;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (cnt_reg != '0);
    assign accept    = start && !busy;

    // register file, writes beyond shift_y are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_a_reg   <= aipt_pkg::ONE_FIX;
            lin_b_reg   <= '0;
            lin_c_reg   <= '0;
            lin_d_reg   <= aipt_pkg::ONE_FIX;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                aipt_pkg::REG_LIN_A:   lin_a_reg   <= cfg_data;
                aipt_pkg::REG_LIN_B:   lin_b_reg   <= cfg_data;
                aipt_pkg::REG_LIN_C:   lin_c_reg   <= cfg_data;
                aipt_pkg::REG_LIN_D:   lin_d_reg   <= cfg_data;
                aipt_pkg::REG_SHIFT_X: shift_x_reg <= cfg_data;
                aipt_pkg::REG_SHIFT_Y: shift_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // settle counter: reloads on every write
    always_comb
    begin
        if (cfg_wr)
            cnt_next = aipt_pkg::CNT_W'(aipt_pkg::PIPE_LAT);
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= aipt_pkg::CNT_W'(aipt_pkg::PIPE_LAT);
        else
            cnt_reg <= cnt_next;
    end

    aipt_inv_terms u_inv (
        .clk   (clk),
        .lin_a (lin_a_reg),
        .lin_b (lin_b_reg),
        .lin_c (lin_c_reg),
        .lin_d (lin_d_reg),
        .terms (terms)
    );

    aipt_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .point_x   (point_x),
        .point_y   (point_y),
        .shift_x   (shift_x_reg),
        .shift_y   (shift_y_reg),
        .terms     (terms),
        .done      (done),
        .x_out     (x_out),
        .y_out     (y_out),
        .singular  (singular),
        .saturated (saturated)
    );

    // every result comes from an accepted request
    a_done_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without request");

    // a config write always holds requests off
    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> busy)
        else $error("busy low after config write");

    // busy only rises after a write
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(cfg_wr))
        else $error("busy rose without config write");

    // no request taken straight after a write
    a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_wr) |-> !accept)
        else $error("request taken while terms settle");

endmodule

>>> src/aipt_div_cell.sv
// aipt_div_cell: one restoring division step for all four inverse terms
// depends on aipt_pkg

module aipt_div_cell (
    input  logic                 clk,
    input  logic [4:0]           bit_idx,
    input  aipt_pkg::cell_t      c_in,
    output aipt_pkg::cell_t      c_out
);

    aipt_pkg::cell_t c_reg;
    aipt_pkg::cell_t c_next;

    always_comb
    begin
        logic [aipt_pkg::CW-1:0] r_sh;
        logic [aipt_pkg::CW-1:0] d_ext;
        logic [aipt_pkg::NW+aipt_pkg::DW-1:0] d_sh;
        c_next = c_in;
        d_ext  = aipt_pkg::CW'(c_in.dabs);
        d_sh   = (aipt_pkg::NW+aipt_pkg::DW)'(c_in.dabs) << bit_idx;
        for (int l = 0; l < aipt_pkg::LANES; l++)
        begin
            r_sh = aipt_pkg::CW'(c_in.rem[l] >> bit_idx);
            if (r_sh >= d_ext)
            begin
                c_next.rem[l] = c_in.rem[l] - aipt_pkg::NW'(d_sh);
                c_next.quo[l] = c_in.quo[l] | (aipt_pkg::QW'(1) << bit_idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign c_out = c_reg;

endmodule

>>> src/aipt_inv_terms.sv
// aipt_inv_terms: determinant, chain of division cells and inverse term clamp
// depends on aipt_pkg and aipt_div_cell

module aipt_inv_terms (
    input  logic                 clk,
    input  logic signed [31:0]   lin_a,
    input  logic signed [31:0]   lin_b,
    input  logic signed [31:0]   lin_c,
    input  logic signed [31:0]   lin_d,
    output aipt_pkg::terms_t     terms
);

    logic signed [63:0]          p_reg;
    logic signed [63:0]          q_reg;
    logic signed [aipt_pkg::DW-1:0] det_reg;
    logic signed [aipt_pkg::DW-1:0] det_next;
    logic [aipt_pkg::DW-1:0]     dabs_reg;
    logic                        sing_reg;
    logic [aipt_pkg::LANES-1:0][aipt_pkg::NW-1:0] nabs_reg;
    logic [aipt_pkg::LANES-1:0]  neg_reg;
    aipt_pkg::cell_t             head_reg;
    aipt_pkg::cell_t             chain [aipt_pkg::QW+1];
    aipt_pkg::terms_t            terms_reg;
    aipt_pkg::terms_t            terms_next;

    always_ff @(posedge clk)
    begin
        p_reg <= lin_a * lin_d;
        q_reg <= lin_b * lin_c;
    end

    // exact difference, truncated toward zero
    always_comb
    begin
        logic signed [64:0] diff;
        logic signed [aipt_pkg::DW-1:0] fl;
        diff     = {p_reg[63], p_reg} - {q_reg[63], q_reg};
        fl       = aipt_pkg::DW'(diff >>> aipt_pkg::FRAC_BITS);
        det_next = fl + aipt_pkg::DW'(diff[64] && (diff[aipt_pkg::FRAC_BITS-1:0] != '0));
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
    end

    always_ff @(posedge clk)
    begin
        logic [32:0] va [aipt_pkg::LANES];
        logic [aipt_pkg::LANES-1:0] vn;
        va[0] = lin_d[31] ? -{1'b1, lin_d} : {1'b0, lin_d};
        va[1] = lin_b[31] ? -{1'b1, lin_b} : {1'b0, lin_b};
        va[2] = lin_c[31] ? -{1'b1, lin_c} : {1'b0, lin_c};
        va[3] = lin_a[31] ? -{1'b1, lin_a} : {1'b0, lin_a};
        vn    = {lin_a[31], !lin_c[31], !lin_b[31], lin_d[31]};
        dabs_reg <= det_reg[aipt_pkg::DW-1] ? -det_reg : det_reg;
        sing_reg <= (det_reg == '0);
        for (int l = 0; l < aipt_pkg::LANES; l++)
        begin
            nabs_reg[l] <= aipt_pkg::NW'(va[l]) << aipt_pkg::FRAC_BITS;
            neg_reg[l]  <= vn[l] ^ det_reg[aipt_pkg::DW-1];
        end
    end

    // quotient of 2^31 or more clamps
    always_ff @(posedge clk)
    begin
        head_reg.dabs <= dabs_reg;
        head_reg.sing <= sing_reg;
        head_reg.neg  <= neg_reg;
        head_reg.rem  <= nabs_reg;
        head_reg.quo  <= '0;
        for (int l = 0; l < aipt_pkg::LANES; l++)
        begin
            head_reg.ovf[l] <= aipt_pkg::CW'(nabs_reg[l] >> aipt_pkg::QW)
                               >= aipt_pkg::CW'(dabs_reg);
        end
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < aipt_pkg::QW; i++)
    begin : g_cell
        aipt_div_cell u_cell (
            .clk     (clk),
            .bit_idx (5'(aipt_pkg::QW - 1 - i)),
            .c_in    (chain[i]),
            .c_out   (chain[i+1])
        );
    end

    always_comb
    begin
        aipt_pkg::cell_t t;
        logic [aipt_pkg::QW-1:0] mag;
        t = chain[aipt_pkg::QW];
        terms_next.sing = t.sing;
        terms_next.sat  = !t.sing && (t.ovf != '0);
        for (int l = 0; l < aipt_pkg::LANES; l++)
        begin
            mag = t.ovf[l] ? aipt_pkg::TERM_MAX : t.quo[l];
            terms_next.term[l] = t.neg[l] ? -{1'b0, mag} : {1'b0, mag};
        end
        if (t.sing)
        begin
            terms_next.term[0] = aipt_pkg::ONE_FIX;
            terms_next.term[1] = '0;
            terms_next.term[2] = '0;
            terms_next.term[3] = aipt_pkg::ONE_FIX;
        end
    end

    always_ff @(posedge clk)
    begin
        terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

>>> src/aipt_map.sv
// aipt_map: per point pipeline, translation, products and 48-bit saturation
// depends on aipt_pkg

module aipt_map (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic signed [31:0]   point_x,
    input  logic signed [31:0]   point_y,
    input  logic signed [31:0]   shift_x,
    input  logic signed [31:0]   shift_y,
    input  aipt_pkg::terms_t     terms,
    output logic                 done,
    output logic signed [47:0]   x_out,
    output logic signed [47:0]   y_out,
    output logic                 singular,
    output logic                 saturated
);

    logic [1:0]                  vld_reg;
    logic                        done_reg;
    logic signed [32:0]          dx_reg;
    logic signed [32:0]          dy_reg;
    logic signed [64:0]          pr_reg [aipt_pkg::LANES];
    logic signed [47:0]          x_reg;
    logic signed [47:0]          y_reg;
    logic                        sing_reg;
    logic                        sat_reg;
    logic signed [47:0]          x_next;
    logic signed [47:0]          y_next;
    logic                        cx;
    logic                        cy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[0], accept};
            done_reg <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= {point_x[31], point_x} - {shift_x[31], shift_x};
        dy_reg    <= {point_y[31], point_y} - {shift_y[31], shift_y};
        pr_reg[0] <= $signed(terms.term[0]) * dx_reg;
        pr_reg[1] <= $signed(terms.term[1]) * dy_reg;
        pr_reg[2] <= $signed(terms.term[2]) * dx_reg;
        pr_reg[3] <= $signed(terms.term[3]) * dy_reg;
    end

    function automatic logic [48:0] sat48(input logic signed [64:0] p,
                                          input logic signed [64:0] q);
        logic signed [65:0] s;
        logic hi;
        logic lo;
        s  = {p[64], p} + {q[64], q};
        hi = !s[65] && (s[64:47] != '0);
        lo = s[65] && (s[64:47] != '1);
        if (hi)
            sat48 = {1'b1, 1'b0, {47{1'b1}}};
        else if (lo)
            sat48 = {1'b1, 1'b1, {47{1'b0}}};
        else
            sat48 = {1'b0, s[47:0]};
    endfunction

    always_comb
    begin
        {cx, x_next} = sat48(pr_reg[0], pr_reg[1]);
        {cy, y_next} = sat48(pr_reg[2], pr_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        sing_reg <= terms.sing;
        sat_reg  <= terms.sat || cx || cy;
    end

    assign done      = done_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench of affine_inverse_point_transform_unit
// depends on aipt_pkg and the unit's rtl; directed table, then random phases

module tb_top;

    localparam int N_RANDOM  = 800;
    localparam int PHASE_LEN = 100;
    localparam int WD_LIMIT  = 4000;
    localparam int SETTLE    = aipt_pkg::PIPE_LAT + 8;

    localparam logic signed [47:0] OUT_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] OUT_LO = 48'sh8000_0000_0000;
    localparam logic [2:0]         REG_BAD_6 = 3'd6;
    localparam logic [2:0]         REG_BAD_7 = 3'd7;

    typedef struct packed {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic               sing;
        logic               sat;
    } mapped_t;

    // one directed row: a register write or a point request
    typedef struct {
        bit                 is_cfg;
        logic [2:0]         idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        bit                 typed;
        mapped_t            want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [31:0]   point_x;
    logic signed [31:0]   point_y;
    logic                 done;
    logic signed [47:0]   x_out;
    logic signed [47:0]   y_out;
    logic                 singular;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [31:0]          cfg_data;

    affine_inverse_point_transform_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .done(done),
        .x_out(x_out), .y_out(y_out), .singular(singular), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // shadow copy of the matrix registers
    logic signed [31:0] m_a, m_b, m_c, m_d, m_sx, m_sy;

    mapped_t pending_points[$];
    int      errors;
    int      idle_cycles;

    // typed expectation handed to the monitor alongside the request
    logic    typed_en;
    mapped_t typed_want;

    // inverse-map one point through the shadow matrix
    function automatic mapped_t map_point(logic signed [31:0] px, logic signed [31:0] py);
        logic signed [79:0] a, b, c, d, det, ia, ib, ic, id, dx, dy, xo, yo, one, tmax;
        mapped_t r;
        a    = m_a;
        b    = m_b;
        c    = m_c;
        d    = m_d;
        one  = 80'sd1 <<< aipt_pkg::FRAC_BITS;
        tmax = 80'sd2147483647;
        r.sat  = 1'b0;
        r.sing = 1'b0;
        // exact difference, truncated toward zero by signed division
        det = (a * d - b * c) / one;
        if (det == 0)
        begin
            r.sing = 1'b1;
            ia = one;
            ib = 0;
            ic = 0;
            id = one;
        end
        else
        begin
            ia = (d * one) / det;
            ib = (-b * one) / det;
            ic = (-c * one) / det;
            id = (a * one) / det;
            if (ia > tmax) begin ia = tmax;  r.sat = 1'b1; end
            if (ia < -tmax) begin ia = -tmax; r.sat = 1'b1; end
            if (ib > tmax) begin ib = tmax;  r.sat = 1'b1; end
            if (ib < -tmax) begin ib = -tmax; r.sat = 1'b1; end
            if (ic > tmax) begin ic = tmax;  r.sat = 1'b1; end
            if (ic < -tmax) begin ic = -tmax; r.sat = 1'b1; end
            if (id > tmax) begin id = tmax;  r.sat = 1'b1; end
            if (id < -tmax) begin id = -tmax; r.sat = 1'b1; end
        end
        dx = 80'(px) - 80'(m_sx);
        dy = 80'(py) - 80'(m_sy);
        xo = ia * dx + ib * dy;
        yo = ic * dx + id * dy;
        if (xo > 80'(OUT_HI)) begin xo = 80'(OUT_HI); r.sat = 1'b1; end
        if (xo < 80'(OUT_LO)) begin xo = 80'(OUT_LO); r.sat = 1'b1; end
        if (yo > 80'(OUT_HI)) begin yo = 80'(OUT_HI); r.sat = 1'b1; end
        if (yo < 80'(OUT_LO)) begin yo = 80'(OUT_LO); r.sat = 1'b1; end
        r.x = xo[47:0];
        r.y = yo[47:0];
        return r;
    endfunction

    // monitor: accepted requests, config writes and results, all sampled at the edge
    always @(posedge clk)
    begin
        mapped_t got, want;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    aipt_pkg::REG_LIN_A:   m_a  <= cfg_data;
                    aipt_pkg::REG_LIN_B:   m_b  <= cfg_data;
                    aipt_pkg::REG_LIN_C:   m_c  <= cfg_data;
                    aipt_pkg::REG_LIN_D:   m_d  <= cfg_data;
                    aipt_pkg::REG_SHIFT_X: m_sx <= cfg_data;
                    aipt_pkg::REG_SHIFT_Y: m_sy <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                pending_points.push_back(typed_en ? typed_want : map_point(point_x, point_y));
            end
            if (done)
            begin
                moved = 1'b1;
                got = '{x: x_out, y: y_out, sing: singular, sat: saturated};
                if (pending_points.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d", $time, x_out, y_out);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (got.x !== want.x)
                    begin
                        errors++;
                        $display("%0t: x_out expected %0d actual %0d", $time, want.x, got.x);
                    end
                    if (got.y !== want.y)
                    begin
                        errors++;
                        $display("%0t: y_out expected %0d actual %0d", $time, want.y, got.y);
                    end
                    if (got.sing !== want.sing)
                    begin
                        errors++;
                        $display("%0t: singular expected %0b actual %0b",
                                 $time, want.sing, got.sing);
                    end
                    if (got.sat !== want.sat)
                    begin
                        errors++;
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.sat, got.sat);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // send one point request after an idle gap; start stays high across gap 0
    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              int gap, bit typed, mapped_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        point_x    <= px;
        point_y    <= py;
        typed_en   <= typed;
        typed_want <= want;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // drain all results, then write one register, without waiting for busy to fall
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random register value: extremes, plus or minus unity, zero, small or anything
    function automatic logic [31:0] pick_term();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(aipt_pkg::ONE_FIX);
            3: return -32'(aipt_pkg::ONE_FIX);
            4: return 32'($signed($urandom_range(0, 8191)) - 4096);
            5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            6: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_point();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2047)) - 1024);
            default: return $urandom();
        endcase
    endfunction

    row_t    rows[$];
    mapped_t none;

    function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] data);
        row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.px     = data;
        r.py     = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic row_t pt_row(logic signed [31:0] px, logic signed [31:0] py,
                                    bit typed, mapped_t want);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.px     = px;
        r.py     = py;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    initial
    begin
        int gap;
        errors      = 0;
        idle_cycles = 0;
        none        = '0;
        rst_n       = 1'b0;
        start       = 1'b0;
        point_x     = '0;
        point_y     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = aipt_pkg::REG_LIN_A;
        cfg_data    = '0;
        typed_en    = 1'b0;
        typed_want  = '0;
        m_a  = aipt_pkg::ONE_FIX;
        m_b  = 0;
        m_c  = 0;
        m_d  = aipt_pkg::ONE_FIX;
        m_sx = 0;
        m_sy = 0;

        // identity after reset: output is the point with 16 fraction bits
        rows.push_back(pt_row(32'sd0, 32'sd0, 1, '{48'sd0, 48'sd0, 1'b0, 1'b0}));
        rows.push_back(pt_row(32'sh7FFF_FFFF, 32'sh8000_0000, 1,
                              '{48'sh7FFF_FFFF_0000, 48'sh8000_0000_0000, 1'b0, 1'b0}));
        rows.push_back(pt_row(32'sh8000_0000, 32'sh7FFF_FFFF, 1,
                              '{48'sh8000_0000_0000, 48'sh7FFF_FFFF_0000, 1'b0, 1'b0}));
        rows.push_back(pt_row(-32'sd1, 32'sd1, 1, '{-48'sd65536, 48'sd65536, 1'b0, 1'b0}));
        // singular matrix: only the negated shift is applied
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_A, 32'd0));
        rows.push_back(cfg_row(aipt_pkg::REG_SHIFT_X, 32'd5));
        rows.push_back(cfg_row(aipt_pkg::REG_SHIFT_Y, -32'd3));
        rows.push_back(pt_row(32'sd5, -32'sd3, 1, '{48'sd0, 48'sd0, 1'b1, 1'b0}));
        rows.push_back(pt_row(32'sd6, -32'sd2, 1, '{48'sd65536, 48'sd65536, 1'b1, 1'b0}));
        // determinant truncates to zero with tiny terms
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_A, 32'd1));
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_D, 32'd1));
        rows.push_back(pt_row(32'sd7, 32'sd0, 0, none));
        // tiny determinant: inverse terms clamp
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_D, 32'(aipt_pkg::ONE_FIX)));
        rows.push_back(pt_row(32'sd100, 32'sd9, 0, none));
        // full scale shear and rotation-like terms, output saturation
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_A, 32'h8000_0000));
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_B, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_C, 32'h8000_0000));
        rows.push_back(cfg_row(aipt_pkg::REG_LIN_D, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(aipt_pkg::REG_SHIFT_X, 32'h8000_0000));
        rows.push_back(cfg_row(aipt_pkg::REG_SHIFT_Y, 32'h7FFF_FFFF));
        rows.push_back(pt_row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, none));
        // out of range register indexes are ignored
        rows.push_back(cfg_row(REG_BAD_6, 32'h1234_5678));
        rows.push_back(cfg_row(REG_BAD_7, 32'hFFFF_FFFF));
        rows.push_back(pt_row(32'sd17, -32'sd17, 0, none));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].idx, rows[i].px);
            else
                send_point(rows[i].px, rows[i].py, $urandom_range(0, 3),
                           rows[i].typed, rows[i].want);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // new matrix at the head of every phase, every register written
            if (n % PHASE_LEN == 0)
            begin
                write_reg(aipt_pkg::REG_LIN_A, pick_term());
                write_reg(aipt_pkg::REG_LIN_B, pick_term());
                write_reg(aipt_pkg::REG_LIN_C, pick_term());
                write_reg(aipt_pkg::REG_LIN_D, pick_term());
                write_reg(aipt_pkg::REG_SHIFT_X, pick_point());
                write_reg(aipt_pkg::REG_SHIFT_Y, pick_point());
            end
            // burst stretches with no gaps, otherwise a random idle gap drawn anew for each point
            gap = ((n / 25) % 3 == 0) ? 0 : $urandom_range(0, 9);
            // hold off once in a while until the result queue drains
            if (n % 150 == 75)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_points.size() != 0) @(posedge clk);
                gap = 0;
            end
            send_point(pick_point(), pick_point(), gap, 1'b0, none);
        end
        start <= 1'b0;

        while (pending_points.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
